@@ rtl/msc_pkg.sv @@
package msc_pkg;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DONE,
    ST_PREP_MG,
    ST_PREP_SH,
    ST_PREP_END,
    ST_INIT_RD,
    ST_INIT_MUL,
    ST_INIT_ACC,
    ST_INIT_WR,
    ST_SP_ADDR,
    ST_SP_LOAD,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT,
    ST_SP_CHK,
    ST_SP_T,
    ST_TD_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SP_ACC,
    ST_WR_A,
    ST_WR_B,
    ST_UPD_RD,
    ST_UPD_MUL1,
    ST_UPD_V,
    ST_UPD_MUL2,
    ST_UPD_P,
    ST_UPD_WR
  } state_t;

  typedef enum logic [2:0] {
    PH_HORZ,
    PH_VERT,
    PH_HBEND,
    PH_VBEND,
    PH_SHDN,
    PH_SHUP
  } phase_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH    = 3'd0,
    REG_GRID_HEIGHT   = 3'd1,
    REG_REST_SPACING  = 3'd2,
    REG_PARTICLE_MASS = 3'd3,
    REG_GRAVITY       = 3'd4,
    REG_STIFFNESS     = 3'd5,
    REG_DAMPING       = 3'd6,
    REG_TIME_STEP     = 3'd7
  } reg_idx_t;

  typedef logic [2:0][31:0] vec3_t;

  localparam logic signed [32:0] ShearFactor = 33'sd91750;
  localparam logic [4:0]         DimMin      = 5'd3;
  localparam logic [5:0]         SqrtLast    = 6'd31;
  localparam logic [5:0]         DivLast     = 6'd63;

  localparam logic signed [64:0] SatMax = 65'sd2147483647;
  localparam logic signed [64:0] SatMin = -65'sd2147483648;

  function automatic logic [31:0] sat32(input logic signed [64:0] v);
    logic [31:0] res;
    if (v > SatMax) begin
      res = 32'h7fff_ffff;
    end else if (v < SatMin) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/mass_spring_cloth_step.sv @@
// Semi-implicit Euler step of a rectangular mass-spring cloth held in Q16.16 fixed point.
// After reset a clearing pass over all MAX_COLUMNS*MAX_ROWS entries zeroes the position and
// velocity memories, and no request is taken meanwhile. A write request goes from idle
// straight to the done state, and a read passes through a read state first. A step request
// walks the particles once to form gravity and damping forces, then every spring (a square
// root and, for a spring of nonzero length, three divides, each giving one bit per cycle),
// then the particles again for the update (three divides by the mass). The divider is
// shared by the spring and update passes.
// One request is in work at a time; its result is held in an output register.
module mass_spring_cloth_step #(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  msc_pkg::reg_idx_t   cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_particle_index,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic                out_degenerate_spring
);
  import msc_pkg::*;

  localparam int Depth = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int LW    = CW + RW + 1;

  // configuration
  logic [4:0]         gw_r, gh_r;
  logic [30:0]        dx_r, mass_r, kst_r, damp_r, dt_r;
  logic signed [31:0] grav_r;

  // control
  state_t         state_r, state_nxt;
  logic [LW-1:0]  i_r;
  logic           flag_r;
  logic           out_valid_r;

  // datapath
  phase_t             ph_r;
  logic [RW-1:0]      r_r;
  logic [CW-1:0]      c_r;
  logic [1:0]         k_r;
  logic [5:0]         cnt_r;
  logic [CW-1:0]      nw_r;
  logic [RW-1:0]      nh_r;
  logic [LW-1:0]      n_r, pin1_r, pin2_r;
  logic signed [47:0] mg_r;
  logic [32:0]        shear_r;
  logic signed [63:0] prod_r;
  vec3_t              d_r, fa_r, fb_r, wv_r, wp_r, res_r, out_vec_r;
  logic               out_flag_r;
  logic [63:0]        sum_r, sq_val_r;
  logic [31:0]        sq_rem_r, len_r;
  logic signed [31:0] t_r;
  logic [63:0]        dv_q_r;
  logic [31:0]        dv_rem_r, dv_den_r;
  logic               dv_neg_r, div_upd_r, rng_r;

  // memories
  vec3_t pos_mem [Depth];
  vec3_t vel_mem [Depth];
  vec3_t frc_mem [Depth];
  vec3_t pos_rda, pos_rdb, vel_rd, frc_rda, frc_rdb;

  logic          pos_we, pos_re, vel_we, vel_re, frc_we, frc_re;
  logic [AW-1:0] pos_waddr, frc_waddr, rd_addr_a, rd_addr_b;
  vec3_t         pos_wdata, vel_wdata, frc_wdata;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;

  // combinational helpers
  logic               accept, in_range, load_out;
  logic [AW-1:0]      in_addr;
  logic [CW-1:0]      nw_cl;
  logic [RW-1:0]      nh_cl;
  logic [30:0]        m_eff;
  logic signed [63:0] prod_sh;
  logic signed [64:0] prod_sh65;
  logic signed [63:0] q_signed;
  logic [63:0]        sum_nxt, prod_mag;
  logic [32:0]        l0;
  logic [31:0]        diff;
  logic [33:0]        sq_rsh, sq_trial;
  logic               sq_ge;
  logic [32:0]        dv_rsh;
  logic               dv_ge;
  logic [LW-1:0]      a_full, b_full;
  logic               col_major, r_last, c_last, sp_last, i_last, clear_last;
  logic [RW-1:0]      r_start, r_end, r_adv;
  logic [CW-1:0]      c_end, c_adv;
  phase_t             ph_adv;

  assign accept     = in_valid && in_ready;
  assign in_addr    = AW'(in_particle_index);
  assign in_range   = int'(in_particle_index) < Depth;
  assign load_out   = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign m_eff      = (mass_r == 31'd0) ? 31'd1 : mass_r;
  assign prod_sh    = prod_r >>> 16;
  assign prod_sh65  = 65'(prod_sh);
  assign q_signed   = dv_neg_r ? -$signed(dv_q_r) : $signed(dv_q_r);
  assign sum_nxt    = sum_r + $unsigned(prod_r);
  assign prod_mag   = prod_r[63] ? $unsigned(-prod_r) : $unsigned(prod_r);
  assign i_last     = (i_r == n_r - LW'(1));
  assign clear_last = (i_r == LW'(Depth - 1));

  always_comb begin
    if (gw_r < DimMin) begin
      nw_cl = CW'(DimMin);
    end else if (int'(gw_r) > MAX_COLUMNS) begin
      nw_cl = CW'(MAX_COLUMNS);
    end else begin
      nw_cl = CW'(gw_r);
    end
    if (gh_r < DimMin) begin
      nh_cl = RW'(DimMin);
    end else if (int'(gh_r) > MAX_ROWS) begin
      nh_cl = RW'(MAX_ROWS);
    end else begin
      nh_cl = RW'(gh_r);
    end
  end

  // spring walk
  assign a_full = LW'(r_r) * LW'(nw_r) + LW'(c_r);

  always_comb begin
    col_major = 1'b0;
    r_start   = '0;
    r_end     = nh_r;
    c_end     = nw_r - CW'(1);
    b_full    = a_full + LW'(1);
    l0        = {2'b00, dx_r};
    unique case (ph_r)
      PH_HORZ: begin
      end
      PH_VERT: begin
        col_major = 1'b1;
        r_end     = nh_r - RW'(1);
        c_end     = nw_r;
        b_full    = a_full + LW'(nw_r);
      end
      PH_HBEND: begin
        c_end  = nw_r - CW'(2);
        b_full = a_full + LW'(2);
        l0     = {1'b0, dx_r, 1'b0};
      end
      PH_VBEND: begin
        col_major = 1'b1;
        r_end     = nh_r - RW'(2);
        c_end     = nw_r;
        b_full    = a_full + LW'(nw_r) + LW'(nw_r);
        l0        = {1'b0, dx_r, 1'b0};
      end
      PH_SHDN: begin
        r_end  = nh_r - RW'(1);
        b_full = a_full + LW'(nw_r) + LW'(1);
        l0     = shear_r;
      end
      PH_SHUP: begin
        r_start = RW'(1);
        b_full  = a_full - LW'(nw_r) + LW'(1);
        l0      = shear_r;
      end
      default: begin
      end
    endcase
  end

  assign r_last  = (r_r + RW'(1) == r_end);
  assign c_last  = (c_r + CW'(1) == c_end);
  assign sp_last = (ph_r == PH_SHUP) && r_last && c_last;

  always_comb begin
    ph_adv = ph_r;
    r_adv  = r_r;
    c_adv  = c_r;
    if (r_last && c_last) begin
      ph_adv = phase_t'(ph_r + 3'd1);
      r_adv  = (ph_adv == PH_SHUP) ? RW'(1) : '0;
      c_adv  = '0;
    end else if (col_major) begin
      if (!r_last) begin
        r_adv = r_r + RW'(1);
      end else begin
        r_adv = r_start;
        c_adv = c_r + CW'(1);
      end
    end else begin
      if (!c_last) begin
        c_adv = c_r + CW'(1);
      end else begin
        c_adv = '0;
        r_adv = r_r + RW'(1);
      end
    end
  end

  assign diff = sat32(65'($signed({1'b0, l0})) - 65'($signed({1'b0, len_r})));

  // square root and divide steps
  assign sq_rsh   = {sq_rem_r, sq_val_r[63:62]};
  assign sq_trial = {len_r, 2'b01};
  assign sq_ge    = (sq_rsh >= sq_trial);
  assign dv_rsh   = {dv_rem_r, dv_q_r[63]};
  assign dv_ge    = (dv_rsh >= {1'b0, dv_den_r});

  assign mul_full = mul_a * mul_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clear_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_READ: state_nxt = ST_READ;
            CMD_STEP: state_nxt = ST_PREP_MG;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_READ:     state_nxt = ST_DONE;
      ST_DONE:     if (load_out) state_nxt = ST_IDLE;
      ST_PREP_MG:  state_nxt = ST_PREP_SH;
      ST_PREP_SH:  state_nxt = ST_PREP_END;
      ST_PREP_END: state_nxt = ST_INIT_RD;
      ST_INIT_RD:  state_nxt = ST_INIT_MUL;
      ST_INIT_MUL: state_nxt = ST_INIT_ACC;
      ST_INIT_ACC: state_nxt = (k_r == 2'd2) ? ST_INIT_WR : ST_INIT_MUL;
      ST_INIT_WR:  state_nxt = i_last ? ST_SP_ADDR : ST_INIT_RD;
      ST_SP_ADDR:  state_nxt = ST_SP_LOAD;
      ST_SP_LOAD:  state_nxt = ST_SQ_MUL;
      ST_SQ_MUL:   state_nxt = ST_SQ_ACC;
      ST_SQ_ACC:   state_nxt = (k_r == 2'd2) ? ST_SQRT : ST_SQ_MUL;
      ST_SQRT:     if (cnt_r == SqrtLast) state_nxt = ST_SP_CHK;
      ST_SP_CHK: begin
        if (len_r != 32'd0) begin
          state_nxt = ST_SP_T;
        end else begin
          state_nxt = sp_last ? ST_UPD_RD : ST_SP_ADDR;
        end
      end
      ST_SP_T:     state_nxt = ST_TD_MUL;
      ST_TD_MUL:   state_nxt = ST_DIV_LOAD;
      ST_DIV_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == DivLast) state_nxt = div_upd_r ? ST_UPD_V : ST_SP_ACC;
      end
      ST_SP_ACC:   state_nxt = (k_r == 2'd2) ? ST_WR_A : ST_TD_MUL;
      ST_WR_A:     state_nxt = ST_WR_B;
      ST_WR_B:     state_nxt = sp_last ? ST_UPD_RD : ST_SP_ADDR;
      ST_UPD_RD:   state_nxt = ST_UPD_MUL1;
      ST_UPD_MUL1: state_nxt = ST_DIV_LOAD;
      ST_UPD_V:    state_nxt = ST_UPD_MUL2;
      ST_UPD_MUL2: state_nxt = ST_UPD_P;
      ST_UPD_P:    state_nxt = (k_r == 2'd2) ? ST_UPD_WR : ST_UPD_MUL1;
      ST_UPD_WR:   state_nxt = i_last ? ST_DONE : ST_UPD_RD;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    pos_we    = 1'b0;
    pos_re    = 1'b0;
    vel_we    = 1'b0;
    vel_re    = 1'b0;
    frc_we    = 1'b0;
    frc_re    = 1'b0;
    pos_waddr = i_r[AW-1:0];
    frc_waddr = i_r[AW-1:0];
    pos_wdata = '0;
    vel_wdata = '0;
    frc_wdata = fa_r;
    rd_addr_a = i_r[AW-1:0];
    rd_addr_b = b_full[AW-1:0];
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_CLEAR: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        rd_addr_a = in_addr;
        pos_waddr = in_addr;
        pos_wdata = {in_z, in_y, in_x};
        pos_we    = in_valid && (in_command == CMD_WRITE) && in_range;
        pos_re    = in_valid && (in_command == CMD_READ);
      end
      ST_PREP_MG: begin
        mul_a = $signed({2'b00, m_eff});
        mul_b = 33'(grav_r);
      end
      ST_PREP_SH: begin
        mul_a = $signed({2'b00, dx_r});
        mul_b = ShearFactor;
      end
      ST_INIT_RD: vel_re = 1'b1;
      ST_INIT_MUL: begin
        mul_a = $signed({2'b00, damp_r});
        mul_b = 33'($signed(vel_rd[k_r]));
      end
      ST_INIT_WR: frc_we = 1'b1;
      ST_SP_ADDR: begin
        rd_addr_a = a_full[AW-1:0];
        pos_re    = 1'b1;
        frc_re    = 1'b1;
      end
      ST_SQ_MUL: begin
        mul_a = 33'($signed(d_r[k_r]));
        mul_b = 33'($signed(d_r[k_r]));
      end
      ST_SP_CHK: begin
        mul_a = $signed({2'b00, kst_r});
        mul_b = 33'($signed(diff));
      end
      ST_TD_MUL: begin
        mul_a = 33'(t_r);
        mul_b = 33'($signed(d_r[k_r]));
      end
      ST_WR_A: begin
        frc_we    = 1'b1;
        frc_waddr = a_full[AW-1:0];
      end
      ST_WR_B: begin
        frc_we    = 1'b1;
        frc_waddr = b_full[AW-1:0];
        frc_wdata = fb_r;
      end
      ST_UPD_RD: begin
        pos_re = 1'b1;
        vel_re = 1'b1;
        frc_re = 1'b1;
      end
      ST_UPD_MUL1: begin
        mul_a = $signed({2'b00, dt_r});
        mul_b = 33'($signed(frc_rda[k_r]));
      end
      ST_UPD_MUL2: begin
        mul_a = $signed({2'b00, dt_r});
        mul_b = 33'($signed(wv_r[k_r]));
      end
      ST_UPD_WR: begin
        vel_we    = 1'b1;
        vel_wdata = wv_r;
        pos_wdata = wp_r;
        pos_we    = (i_r != pin1_r) && (i_r != pin2_r);
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    if (pos_re) begin
      pos_rda <= pos_mem[rd_addr_a];
      pos_rdb <= pos_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (vel_we) vel_mem[i_r[AW-1:0]] <= vel_wdata;
    if (vel_re) vel_rd <= vel_mem[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (frc_we) frc_mem[frc_waddr] <= frc_wdata;
    if (frc_re) begin
      frc_rda <= frc_mem[rd_addr_a];
      frc_rdb <= frc_mem[rd_addr_b];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r   <= 5'd16;
      gh_r   <= 5'd16;
      dx_r   <= 31'd65536;
      mass_r <= 31'd65536;
      grav_r <= 32'sd642253;
      kst_r  <= 31'd65536;
      damp_r <= 31'd0;
      dt_r   <= 31'd655;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:    gw_r   <= cfg_wdata[4:0];
        REG_GRID_HEIGHT:   gh_r   <= cfg_wdata[4:0];
        REG_REST_SPACING:  dx_r   <= cfg_wdata[30:0];
        REG_PARTICLE_MASS: mass_r <= cfg_wdata[30:0];
        REG_GRAVITY:       grav_r <= $signed(cfg_wdata);
        REG_STIFFNESS:     kst_r  <= cfg_wdata[30:0];
        REG_DAMPING:       damp_r <= cfg_wdata[30:0];
        REG_TIME_STEP:     dt_r   <= cfg_wdata[30:0];
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      i_r         <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_CLEAR:    i_r <= i_r + LW'(1);
        ST_PREP_END: i_r <= '0;
        ST_INIT_WR:  i_r <= i_last ? '0 : i_r + LW'(1);
        ST_UPD_WR:   i_r <= i_r + LW'(1);
        default: begin
        end
      endcase
      if (accept && (in_command == CMD_STEP)) begin
        flag_r <= 1'b0;
      end else if ((state_r == ST_SP_CHK) && (len_r == 32'd0)) begin
        flag_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_full[63:0];
    if (load_out) begin
      out_vec_r  <= res_r;
      out_flag_r <= flag_r;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          nw_r  <= nw_cl;
          nh_r  <= nh_cl;
          rng_r <= in_range;
          res_r <= '0;
        end
      end
      ST_READ: if (rng_r) res_r <= pos_rda;
      ST_PREP_MG: n_r <= LW'(nw_r) * LW'(nh_r);
      ST_PREP_SH: begin
        mg_r   <= prod_sh[47:0];
        pin1_r <= n_r - LW'(nw_r);
        pin2_r <= n_r - LW'(1);
      end
      ST_PREP_END: shear_r <= prod_sh[32:0];
      ST_INIT_RD:  k_r <= '0;
      ST_INIT_ACC: begin
        if (k_r == 2'd1) begin
          fa_r[k_r] <= sat32(-65'(mg_r) - prod_sh65);
        end else begin
          fa_r[k_r] <= sat32(-prod_sh65);
        end
        k_r <= k_r + 2'd1;
      end
      ST_INIT_WR: begin
        ph_r <= PH_HORZ;
        r_r  <= '0;
        c_r  <= '0;
      end
      ST_SP_LOAD: begin
        for (int j = 0; j < 3; j++) begin
          d_r[j] <= sat32(65'($signed(pos_rda[j])) - 65'($signed(pos_rdb[j])));
        end
        fa_r  <= frc_rda;
        fb_r  <= frc_rdb;
        k_r   <= '0;
        sum_r <= '0;
      end
      ST_SQ_ACC: begin
        sum_r    <= sum_nxt;
        k_r      <= k_r + 2'd1;
        sq_val_r <= sum_nxt;
        sq_rem_r <= '0;
        len_r    <= '0;
        cnt_r    <= '0;
      end
      ST_SQRT: begin
        sq_rem_r <= sq_ge ? 32'(sq_rsh - sq_trial) : sq_rsh[31:0];
        len_r    <= {len_r[30:0], sq_ge};
        sq_val_r <= {sq_val_r[61:0], 2'b00};
        cnt_r    <= cnt_r + 6'd1;
      end
      ST_SP_CHK: begin
        if (len_r == 32'd0) begin
          ph_r <= ph_adv;
          r_r  <= r_adv;
          c_r  <= c_adv;
        end
      end
      ST_SP_T: begin
        t_r <= $signed(sat32(prod_sh65));
        k_r <= '0;
      end
      ST_TD_MUL: div_upd_r <= 1'b0;
      ST_DIV_LOAD: begin
        dv_q_r   <= prod_mag;
        dv_rem_r <= '0;
        dv_den_r <= div_upd_r ? {1'b0, m_eff} : len_r;
        dv_neg_r <= prod_r[63];
        cnt_r    <= '0;
      end
      ST_DIV: begin
        dv_rem_r <= dv_ge ? 32'(dv_rsh - {1'b0, dv_den_r}) : dv_rsh[31:0];
        dv_q_r   <= {dv_q_r[62:0], dv_ge};
        cnt_r    <= cnt_r + 6'd1;
      end
      ST_SP_ACC: begin
        fa_r[k_r] <= sat32(65'($signed(fa_r[k_r])) + 65'(q_signed));
        fb_r[k_r] <= sat32(65'($signed(fb_r[k_r])) - 65'(q_signed));
        k_r       <= k_r + 2'd1;
      end
      ST_WR_B: begin
        ph_r <= ph_adv;
        r_r  <= r_adv;
        c_r  <= c_adv;
      end
      ST_UPD_RD:   k_r <= '0;
      ST_UPD_MUL1: div_upd_r <= 1'b1;
      ST_UPD_V: begin
        wv_r[k_r] <= sat32(65'($signed(vel_rd[k_r])) + 65'(q_signed));
      end
      ST_UPD_P: begin
        wp_r[k_r] <= sat32(65'($signed(pos_rda[k_r])) + prod_sh65);
        k_r       <= k_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_x                 = $signed(out_vec_r[0]);
  assign out_y                 = $signed(out_vec_r[1]);
  assign out_z                 = $signed(out_vec_r[2]);
  assign out_degenerate_spring = out_flag_r;

`ifndef SYNTHESIS
  a_spring_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SP_ADDR) |-> ((a_full < n_r) && (b_full < n_r)))
    else $error("spring end outside the grid");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the done state");

  a_corner_pinned: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_UPD_WR) && ((i_r == pin1_r) || (i_r == pin2_r))) |-> !pos_we)
    else $error("pinned corner position overwritten");
`endif

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  import msc_pkg::*;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               degen;
  } readout_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  reg_idx_t           cfg_index = REG_GRID_WIDTH;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_command = CMD_NOP;
  logic [7:0]         in_particle_index = '0;
  logic signed [31:0] in_x = '0;
  logic signed [31:0] in_y = '0;
  logic signed [31:0] in_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               out_degenerate_spring;

  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       mismatches = 0;
  readout_t readout_q[$];

  // cloth state as the testbench predicts it
  int          pos[256][3];
  int          vel[256][3];
  int          frc[256][3];
  bit          degen_flag;
  logic [4:0]  cfg_w, cfg_h;
  logic [30:0] cfg_spacing, cfg_mass, cfg_k, cfg_c, cfg_dt;
  logic signed [31:0] cfg_g;

  mass_spring_cloth_step u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_particle_index     (in_particle_index),
    .in_x                  (in_x),
    .in_y                  (in_y),
    .in_z                  (in_z),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_x                 (out_x),
    .out_y                 (out_y),
    .out_z                 (out_z),
    .out_degenerate_spring (out_degenerate_spring)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int clamp_dim(logic [4:0] v);
    if (v < 3) return 3;
    if (v > 16) return 16;
    return int'(v);
  endfunction

  function automatic void apply_spring(int a, int b, longint l0);
    longint d[3];
    longint unsigned sum;
    longint len, diff, t, f;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = sat(longint'(pos[a][k]) - longint'(pos[b][k]));
      sum += longint'(d[k] * d[k]);
    end
    len = longint'(isqrt(sum));
    if (len == 0) begin
      degen_flag = 1'b1;
      return;
    end
    diff = sat(l0 - len);
    t = sat((longint'(cfg_k) * diff) >>> 16);
    for (int k = 0; k < 3; k++) begin
      f = (t * d[k]) / len;
      frc[a][k] = sat(longint'(frc[a][k]) + f);
      frc[b][k] = sat(longint'(frc[b][k]) - f);
    end
  endfunction

  function automatic void advance_cloth();
    int nw, nh, n, pin1, pin2;
    int keep1[3], keep2[3];
    longint m, dx, l_bend, l_shear, mg, dt, cv, base, dv;
    int v;
    nw = clamp_dim(cfg_w);
    nh = clamp_dim(cfg_h);
    n = nw * nh;
    pin1 = (nh - 1) * nw;
    pin2 = (nh - 1) * nw + nw - 1;
    m = (cfg_mass == 0) ? 64'sd1 : longint'(cfg_mass);
    dx = longint'(cfg_spacing);
    l_bend = 2 * dx;
    l_shear = (dx * 91750) >>> 16;
    mg = (m * longint'(cfg_g)) >>> 16;
    dt = longint'(cfg_dt);
    keep1 = pos[pin1];
    keep2 = pos[pin2];
    degen_flag = 1'b0;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        cv = (longint'(cfg_c) * longint'(vel[i][k])) >>> 16;
        base = (k == 1) ? -mg : 64'sd0;
        frc[i][k] = sat(base - cv);
      end
    end
    for (int r = 0; r < nh; r++)
      for (int c = 0; c + 1 < nw; c++) apply_spring(r*nw + c, r*nw + c + 1, dx);
    for (int c = 0; c < nw; c++)
      for (int r = 0; r + 1 < nh; r++) apply_spring(r*nw + c, (r+1)*nw + c, dx);
    for (int r = 0; r < nh; r++)
      for (int c = 0; c + 2 < nw; c++) apply_spring(r*nw + c, r*nw + c + 2, l_bend);
    for (int c = 0; c < nw; c++)
      for (int r = 0; r + 2 < nh; r++) apply_spring(r*nw + c, (r+2)*nw + c, l_bend);
    for (int r = 0; r + 1 < nh; r++)
      for (int c = 0; c + 1 < nw; c++) apply_spring(r*nw + c, (r+1)*nw + c + 1, l_shear);
    for (int r = 1; r < nh; r++)
      for (int c = 0; c + 1 < nw; c++) apply_spring(r*nw + c, (r-1)*nw + c + 1, l_shear);
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        dv = (dt * longint'(frc[i][k])) / m;
        v = sat(longint'(vel[i][k]) + dv);
        vel[i][k] = v;
        pos[i][k] = sat(longint'(pos[i][k]) + ((dt * longint'(v)) >>> 16));
      end
    end
    pos[pin1] = keep1;
    pos[pin2] = keep2;
  endfunction

  function automatic readout_t predict_readout(cmd_t cmd, int idx, int x, int y, int z);
    readout_t res;
    res = '{0, 0, 0, 1'b0};
    case (cmd)
      CMD_WRITE: begin
        pos[idx][0] = x;
        pos[idx][1] = y;
        pos[idx][2] = z;
      end
      CMD_STEP: advance_cloth();
      CMD_READ: begin
        res.x = pos[idx][0];
        res.y = pos[idx][1];
        res.z = pos[idx][2];
      end
      default: ;
    endcase
    res.degen = degen_flag;
    return res;
  endfunction

  task automatic send_req(cmd_t cmd, int idx, int x = 0, int y = 0, int z = 0);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_particle_index <= idx[7:0];
    in_x <= x;
    in_y <= y;
    in_z <= z;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    readout_q = {readout_q, predict_readout(cmd, idx & 255, x, y, z)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GRID_WIDTH:    cfg_w = d[4:0];
      REG_GRID_HEIGHT:   cfg_h = d[4:0];
      REG_REST_SPACING:  cfg_spacing = d[30:0];
      REG_PARTICLE_MASS: cfg_mass = d[30:0];
      REG_GRAVITY:       cfg_g = d;
      REG_STIFFNESS:     cfg_k = d[30:0];
      REG_DAMPING:       cfg_c = d[30:0];
      REG_TIME_STEP:     cfg_dt = d[30:0];
      default: ;
    endcase
  endtask

  task automatic set_physics(logic [31:0] sp, logic [31:0] m, logic [31:0] g,
                             logic [31:0] k, logic [31:0] c, logic [31:0] dt);
    cfg_write(REG_REST_SPACING, sp);
    cfg_write(REG_PARTICLE_MASS, m);
    cfg_write(REG_GRAVITY, g);
    cfg_write(REG_STIFFNESS, k);
    cfg_write(REG_DAMPING, c);
    cfg_write(REG_TIME_STEP, dt);
  endtask

  task automatic set_grid(int w, int h);
    cfg_write(REG_GRID_WIDTH, w);
    cfg_write(REG_GRID_HEIGHT, h);
  endtask

  // lay the particles out on a jittered lattice
  task automatic load_lattice(int pitch, int jitter);
    int nw, nh;
    nw = clamp_dim(cfg_w);
    nh = clamp_dim(cfg_h);
    for (int i = 0; i < nw * nh; i++) begin
      send_req(CMD_WRITE, i,
               (i % nw) * pitch + $urandom_range(0, jitter) - jitter / 2,
               (i / nw) * pitch + $urandom_range(0, jitter) - jitter / 2,
               $urandom_range(0, jitter) - jitter / 2);
    end
  endtask

  task automatic read_some(int count);
    int n;
    n = clamp_dim(cfg_w) * clamp_dim(cfg_h);
    repeat (count) send_req(CMD_READ, $urandom_range(0, n - 1));
  endtask

  task automatic test_directed();
    set_grid(3, 3);
    // all particles coincide: every spring is degenerate
    send_req(CMD_STEP, 0);
    send_req(CMD_READ, 4);
    send_req(CMD_WRITE, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_req(CMD_WRITE, 255, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_req(CMD_READ, 0);
    send_req(CMD_READ, 255);
    send_req(CMD_NOP, 0);
    send_req(CMD_NOP, 255, -1, -1, -1);
    send_req(CMD_READ, 200);
    load_lattice(65536, 4096);
    send_req(CMD_STEP, 0);
    send_req(CMD_READ, 6);
    send_req(CMD_READ, 8);
    send_req(CMD_READ, 0);
    drain();
  endtask

  task automatic test_config_extremes();
    // clamped to 3 x 16, extreme physics
    set_grid(0, 31);
    set_physics(32'h7fff_ffff, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    load_lattice(65536, 65536);
    send_req(CMD_STEP, 0);
    read_some(5);
    send_req(CMD_STEP, 0);
    read_some(3);
    drain();
    // clamped to 16 x 3
    set_grid(31, 2);
    set_physics(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 1);
    load_lattice(1 << 24, 1 << 20);
    send_req(CMD_STEP, 0);
    read_some(5);
    drain();
    set_grid(4, 4);
    set_physics(65536, 1, 642253, 1 << 20, 1 << 14, 6553);
    load_lattice(65536, 8192);
    send_req(CMD_STEP, 0);
    send_req(CMD_STEP, 0);
    read_some(6);
    drain();
  endtask

  task automatic random_phase(int target);
    int sent, pick, nw, nh;
    sent = 0;
    set_grid($urandom_range(3, 5), $urandom_range(3, 5));
    set_physics($urandom_range(1 << 14, 1 << 18), $urandom_range(1 << 12, 1 << 18),
                $urandom, $urandom_range(0, 1 << 22), $urandom_range(0, 1 << 16),
                $urandom_range(1, 1 << 14));
    nw = clamp_dim(cfg_w);
    nh = clamp_dim(cfg_h);
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        load_lattice($urandom_range(1 << 14, 1 << 18), $urandom_range(0, 1 << 14));
        send_req(CMD_STEP, $urandom_range(0, 255));
        read_some(3);
        sent += nw * nh + 4;
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          send_req(CMD_WRITE, $urandom_range(0, 255), $urandom, $urandom, $urandom);
        end else if (pick < 78) begin
          send_req(CMD_READ, $urandom_range(0, 255));
        end else if (pick < 92) begin
          send_req(CMD_NOP, $urandom_range(0, 255), $urandom, $urandom, $urandom);
        end else begin
          send_req(CMD_STEP, $urandom_range(0, 255), $urandom, $urandom, $urandom);
        end
        sent++;
      end
    end
    drain();
  endtask

  task automatic test_random();
    send_idle_pct = 36;
    recv_idle_pct = 76;
    random_phase(40);
    send_idle_pct = 76;
    recv_idle_pct = 36;
    random_phase(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(40);
  endtask

  always @(negedge clk) begin
    readout_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (readout_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h degen=%b", $time,
                 out_x, out_y, out_z, out_degenerate_spring);
        mismatches++;
      end else begin
        exp_r = readout_q.pop_front();
        if (out_x !== exp_r.x || out_y !== exp_r.y || out_z !== exp_r.z ||
            out_degenerate_spring !== exp_r.degen) begin
          $display("%0t: expected x=%h y=%h z=%h degen=%b, actual x=%h y=%h z=%h degen=%b",
                   $time, exp_r.x, exp_r.y, exp_r.z, exp_r.degen,
                   out_x, out_y, out_z, out_degenerate_spring);
          mismatches++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      pos[i] = '{0, 0, 0};
      vel[i] = '{0, 0, 0};
      frc[i] = '{0, 0, 0};
    end
    degen_flag = 1'b0;
    cfg_w = 16;
    cfg_h = 16;
    cfg_spacing = 65536;
    cfg_mass = 65536;
    cfg_g = 642253;
    cfg_k = 65536;
    cfg_c = 0;
    cfg_dt = 655;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the memory clear has finished
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random();
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/msc_pkg.sv
rtl/mass_spring_cloth_step.sv
dv/tb_top.sv
